>>> hw/rtl/tls_pkg.sv
package tls_pkg;

    // Cube geometry: four axes of SIDE cells, one binary digit per cell
    localparam int SIDE       = 4;
    localparam int SIDE_W     = 2;
    localparam int CELL_W     = 4 * SIDE_W;
    localparam int CELLS      = 1 << CELL_W;
    localparam int LINE_W     = 3 * SIDE_W;
    localparam int VALUE_W    = 4;
    localparam int TABLE_SIZE = 1 << VALUE_W;
    localparam int TABLE_W    = 4;

    localparam logic [1:0] CMD_TABLE_WR = 2'd0;
    localparam logic [1:0] CMD_CELL_WR  = 2'd1;
    localparam logic [1:0] CMD_PASS     = 2'd2;
    localparam logic [1:0] CMD_CELL_RD  = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [VALUE_W-1:0]  table_index;
        logic [TABLE_W-1:0]  table_value;
        logic [CELL_W-1:0]   cell_index;
        logic                cell_digit;
        logic [1:0]          pass_axis;
    } req_word_t;

    typedef struct packed {
        logic read_digit;
        logic done_res;
    } rsp_word_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [CELL_W-1:0] addr;
        logic              wdata;
    } cube_req_t;

    typedef struct packed {
        logic               we;
        logic [VALUE_W-1:0] waddr;
        logic [TABLE_W-1:0] wdata;
        logic               re;
        logic [VALUE_W-1:0] raddr;
    } tbl_req_t;

    // Place the position along the chosen axis into the line number
    function automatic logic [CELL_W-1:0] cell_addr(
        input logic [1:0]        axis,
        input logic [LINE_W-1:0] line,
        input logic [SIDE_W-1:0] pos
    );
        logic [CELL_W-1:0] addr;
        case (axis)
            2'd0:    addr = {pos, line};
            2'd1:    addr = {line[5:4], pos, line[3:0]};
            2'd2:    addr = {line[5:2], pos, line[1:0]};
            default: addr = {line, pos};
        endcase
        return addr;
    endfunction

endpackage

>>> hw/rtl/tls_cube_mem.sv
module tls_cube_mem (
    input  logic                     clk,
    input  tls_pkg::cube_req_t       req,
    output logic                     rdata
);

    logic mem [tls_pkg::CELLS];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tls_table.sv
module tls_table (
    input  logic                            clk,
    input  tls_pkg::tbl_req_t               req,
    output logic [tls_pkg::TABLE_W-1:0]     rdata
);

    logic [tls_pkg::TABLE_W-1:0] entry [tls_pkg::TABLE_SIZE];
    logic [tls_pkg::TABLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= entry[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tesseract_line_substitution_core.sv
// Line substitution over a 4x4x4x4 cube of binary digits.
// req carries one command word (valid/stall): write a table entry, write a
// cell, read a cell, or run a pass along one axis. rsp returns one word per
// command, with done_res set and read_digit holding the cell for a read.
// A pass walks 64 lines; each line takes 4 cube reads, a drain step that
// takes the last read data and issues the table lookup, and 4 cube writes,
// all through the single port of the cube memory.
// One command is in work at a time; req_stall is high until it finishes.
// A finished word waits in the output register while the next command is
// taken; if that register is still full when the next command finishes,
// the sequencer holds until rsp is taken.
// After reset the cube is cleared one cell per cycle, all 256 cells, with
// req_stall high. Table entries come out of reset undefined and must be
// written before a pass looks them up.
module tesseract_line_substitution_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tls_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tls_pkg::rsp_word_t rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RDCELL,
        S_READ,
        S_DRAIN,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t                            state_reg, state_next;
    tls_pkg::req_word_t                item_reg, item_next;
    logic [tls_pkg::CELL_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [tls_pkg::LINE_W-1:0]        line_reg, line_next;
    logic [tls_pkg::SIDE_W-1:0]        pos_reg, pos_next;
    logic [tls_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic                              rd_valid_reg, rd_valid_next;
    logic                              digit_reg, digit_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    tls_pkg::rsp_word_t                rsp_reg, rsp_next;

    tls_pkg::cube_req_t                cube_req;
    tls_pkg::tbl_req_t                 tbl_req;
    logic                              cube_rdata;
    logic [tls_pkg::TABLE_W-1:0]       tbl_rdata;
    logic [tls_pkg::CELL_W-1:0]        line_addr;

    tls_cube_mem u_cube (
        .clk   (clk),
        .req   (cube_req),
        .rdata (cube_rdata)
    );

    tls_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    assign line_addr = tls_pkg::cell_addr(item_reg.pass_axis, line_reg, pos_reg);

    // Shift in each digit as its read data returns, first cell most significant
    assign value_next = rd_valid_reg ? {value_reg[tls_pkg::VALUE_W-2:0], cube_rdata}
                                     : value_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        clr_cnt_next   = clr_cnt_reg;
        line_next      = line_reg;
        pos_next       = pos_reg;
        rd_valid_next  = 1'b0;
        digit_next     = digit_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cube_req       = '0;
        tbl_req        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cube_req.en    = 1'b1;
                cube_req.we    = 1'b1;
                cube_req.addr  = clr_cnt_reg;
                cube_req.wdata = 1'b0;
                clr_cnt_next   = clr_cnt_reg + tls_pkg::CELL_W'(1);
                if (clr_cnt_reg == tls_pkg::CELL_W'(tls_pkg::CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                digit_next = 1'b0;
                case (item_reg.cmd)
                    tls_pkg::CMD_TABLE_WR:
                    begin
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = item_reg.table_index;
                        tbl_req.wdata = item_reg.table_value;
                        state_next    = S_FINISH;
                    end
                    tls_pkg::CMD_CELL_WR:
                    begin
                        cube_req.en    = 1'b1;
                        cube_req.we    = 1'b1;
                        cube_req.addr  = item_reg.cell_index;
                        cube_req.wdata = item_reg.cell_digit;
                        state_next     = S_FINISH;
                    end
                    tls_pkg::CMD_PASS:
                    begin
                        line_next  = '0;
                        pos_next   = '0;
                        state_next = S_READ;
                    end
                    default:
                    begin
                        cube_req.en   = 1'b1;
                        cube_req.addr = item_reg.cell_index;
                        state_next    = S_RDCELL;
                    end
                endcase
            end
            S_RDCELL:
            begin
                digit_next = cube_rdata;
                state_next = S_FINISH;
            end
            S_READ:
            begin
                cube_req.en   = 1'b1;
                cube_req.addr = line_addr;
                rd_valid_next = 1'b1;
                pos_next      = pos_reg + tls_pkg::SIDE_W'(1);
                if (pos_reg == tls_pkg::SIDE_W'(tls_pkg::SIDE - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                tbl_req.re    = 1'b1;
                tbl_req.raddr = value_next;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cube_req.en    = 1'b1;
                cube_req.we    = 1'b1;
                cube_req.addr  = line_addr;
                cube_req.wdata = tbl_rdata[tls_pkg::SIDE_W'(tls_pkg::SIDE - 1) - pos_reg];
                pos_next       = pos_reg + tls_pkg::SIDE_W'(1);
                if (pos_reg == tls_pkg::SIDE_W'(tls_pkg::SIDE - 1))
                begin
                    line_next = line_reg + tls_pkg::LINE_W'(1);
                    if (line_reg == '1)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.read_digit = digit_reg;
                    rsp_next.done_res   = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        line_reg  <= line_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
        digit_reg <= digit_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The last digit of a line must be in flight when the lookup is issued
    a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> rd_valid_reg)
        else $error("line lookup issued without last digit");

    // A new response word appears only out of the finish step
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("response raised outside finish");

    // Finish with a free output register reaches idle, response valid, in the next cycle
    a_finish_moves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !rsp_valid_reg |=> state_reg == S_IDLE && rsp_valid_reg)
        else $error("finish did not deliver");

    // The table is never written and looked up in the same cycle
    a_tbl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_req.we && tbl_req.re))
        else $error("table write and lookup collide");

endmodule
